>>> hdl/bsf_pkg.sv
// shared constants, codes and types of the bitmap shape fill engine
`timescale 1ns / 1ps

package bsf_pkg;

    // canvas geometry
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int CNT_W       = ROW_W + 1;

    // field and register widths
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SIZE_W    = 7;
    localparam int POS_W     = 6;
    localparam int STATUS_W  = 2;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // command codes
    localparam logic [1:0] MODE_SQUARE   = 2'd0;
    localparam logic [1:0] MODE_TRIANGLE = 2'd1;
    localparam logic [1:0] MODE_LINE     = 2'd2;
    localparam logic [1:0] MODE_READ     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SLOPE = 2'd2;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_DRAW,
        JOB_READ
    } t_job_kind;

    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_INC,
        STEP_DEC
    } t_step;

    // one classified command: a run of rows, each filled over columns lo..hi
    typedef struct packed {
        t_job_kind            kind;
        logic [STATUS_W-1:0]  status;
        logic [ROW_W-1:0]     row;
        logic                 row_up;
        logic [CNT_W-1:0]     count;
        logic [COL_W-1:0]     lo;
        logic [COL_W-1:0]     hi;
        t_step                lo_step;
        t_step                hi_step;
    } t_job;

    // queue read side as seen by the back end
    typedef struct packed {
        logic empty;
        t_job job;
    } t_queue_rd;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DRAW,
        BK_READ,
        BK_READ_DATA,
        BK_FINISH
    } t_back_state;

endpackage

>>> hdl/bitmap_shape_fill_engine.sv
// top level of the bitmap shape fill engine
`timescale 1ns / 1ps

// One-bit-per-pixel canvas of 64 rows by 64 columns, blank after reset, that
// takes square, triangle, line and row-read commands and returns one result
// per command in command order. The front end checks bounds and turns each
// command into a run of rows with a column span per row; a two-entry job
// queue lets it keep taking commands while the back end works. The back end
// does one read-modify-write of a canvas row per cycle through the canvas
// ram. Each job is picked up from the queue, then drawn row by row or read,
// and a finish step hands its result to the output register once that is
// free, after which the next job is picked up. A finished result sits in an
// output register until popped, while the next command is already being
// worked on. The user must write width and height only while the block is
// idle; the block itself does not enforce it.
module bitmap_shape_fill_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bsf_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [1:0]                         i_mode,
    input  logic [bsf_pkg::SIZE_W-1:0]         i_size,
    input  logic [bsf_pkg::POS_W-1:0]          i_x_start,
    input  logic [bsf_pkg::POS_W-1:0]          i_y_start,
    input  logic [bsf_pkg::POS_W-1:0]          i_x_end,
    input  logic [bsf_pkg::POS_W-1:0]          i_y_end,
    input  logic [1:0]                         i_corner,
    output logic                               empty,
    input  logic                               pop,
    output logic [bsf_pkg::STATUS_W-1:0]       o_status,
    output logic [bsf_pkg::MAX_COLUMNS-1:0]    o_row_bits
);

    bsf_pkg::t_job      front_job;
    bsf_pkg::t_queue_rd q_rd;
    logic               q_pop;

    // command decode and configuration
    bsf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_mode),
        .i_size      (i_size),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_corner    (i_corner),
        .o_job       (front_job)
    );

    // job queue, full backs up the input transaction
    bsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    // canvas sequencer and result register
    bsf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_rd),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_status   (o_status),
        .o_row_bits (o_row_bits)
    );

endmodule

>>> hdl/bsf_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/bsf_front.sv
// command front end: configuration registers, bounds checks and job decode
`timescale 1ns / 1ps

module bsf_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bsf_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [1:0]                      i_mode,
    input  logic [bsf_pkg::SIZE_W-1:0]      i_size,
    input  logic [bsf_pkg::POS_W-1:0]       i_x_start,
    input  logic [bsf_pkg::POS_W-1:0]       i_y_start,
    input  logic [bsf_pkg::POS_W-1:0]       i_x_end,
    input  logic [bsf_pkg::POS_W-1:0]       i_y_end,
    input  logic [1:0]                      i_corner,
    output bsf_pkg::t_job                   o_job
);

    localparam int SUM_W = bsf_pkg::CFG_W + 2;

    logic [bsf_pkg::CFG_W-1:0] r_width;
    logic [bsf_pkg::CFG_W-1:0] r_height;
    logic [bsf_pkg::CFG_W-1:0] eff_w;
    logic [bsf_pkg::CFG_W-1:0] eff_h;

    logic                       sq_range;
    logic [bsf_pkg::SIZE_W-1:0] tri_w;
    logic                       tri_range;
    logic [bsf_pkg::POS_W-1:0]  ax;
    logic [bsf_pkg::POS_W-1:0]  ay;
    logic                       ln_range;
    logic                       ln_slope;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bsf_pkg::CFG_W'(bsf_pkg::MAX_COLUMNS);
            r_height <= bsf_pkg::CFG_W'(bsf_pkg::MAX_ROWS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsf_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                bsf_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // canvas extent in use, clipped to the storage
    assign eff_w = (r_width > bsf_pkg::CFG_W'(bsf_pkg::MAX_COLUMNS)) ?
                   bsf_pkg::CFG_W'(bsf_pkg::MAX_COLUMNS) : r_width;
    assign eff_h = (r_height > bsf_pkg::CFG_W'(bsf_pkg::MAX_ROWS)) ?
                   bsf_pkg::CFG_W'(bsf_pkg::MAX_ROWS) : r_height;

    // square bounds
    assign sq_range = ((SUM_W'(i_x_start) + SUM_W'(i_size)) > SUM_W'(eff_w)) ||
                      ((SUM_W'(i_y_start) + SUM_W'(i_size)) > SUM_W'(eff_h));

    // triangle bounds: corner bit 0 opens right, bit 1 opens down
    assign tri_w = i_size - bsf_pkg::SIZE_W'(1);

    always_comb begin
        tri_range = (bsf_pkg::CFG_W'(i_x_start) >= eff_w) ||
                    (bsf_pkg::CFG_W'(i_y_start) >= eff_h);
        if (i_corner[0]) begin
            tri_range = tri_range ||
                ((SUM_W'(i_x_start) + SUM_W'(tri_w)) >= SUM_W'(eff_w));
        end else begin
            tri_range = tri_range || (bsf_pkg::SIZE_W'(i_x_start) < tri_w);
        end
        if (i_corner[1]) begin
            tri_range = tri_range ||
                ((SUM_W'(i_y_start) + SUM_W'(tri_w)) >= SUM_W'(eff_h));
        end else begin
            tri_range = tri_range || (bsf_pkg::SIZE_W'(i_y_start) < tri_w);
        end
    end

    // line bounds and slope
    assign ax = (i_x_end > i_x_start) ? (i_x_end - i_x_start) : (i_x_start - i_x_end);
    assign ay = (i_y_end > i_y_start) ? (i_y_end - i_y_start) : (i_y_start - i_y_end);
    assign ln_range = (bsf_pkg::CFG_W'(i_x_start) >= eff_w) ||
                      (bsf_pkg::CFG_W'(i_x_end)   >= eff_w) ||
                      (bsf_pkg::CFG_W'(i_y_start) >= eff_h) ||
                      (bsf_pkg::CFG_W'(i_y_end)   >= eff_h);
    assign ln_slope = (ax != '0) && (ay != '0) && (ax != ay);

    // command to job decode
    always_comb begin
        o_job         = '0;
        o_job.kind    = bsf_pkg::JOB_NONE;
        o_job.status  = bsf_pkg::STATUS_DONE;
        o_job.row     = bsf_pkg::ROW_W'(i_y_start);
        o_job.row_up  = 1'b0;
        o_job.count   = bsf_pkg::CNT_W'(i_size);
        o_job.lo      = bsf_pkg::COL_W'(i_x_start);
        o_job.hi      = bsf_pkg::COL_W'(i_x_start);
        o_job.lo_step = bsf_pkg::STEP_HOLD;
        o_job.hi_step = bsf_pkg::STEP_HOLD;
        unique case (i_mode)
            bsf_pkg::MODE_SQUARE: begin
                if (sq_range) begin
                    o_job.status = bsf_pkg::STATUS_RANGE;
                end else if (i_size != '0) begin
                    o_job.kind = bsf_pkg::JOB_DRAW;
                    o_job.hi   = bsf_pkg::COL_W'(i_x_start) +
                                 bsf_pkg::COL_W'(i_size - bsf_pkg::SIZE_W'(1));
                end
            end
            bsf_pkg::MODE_TRIANGLE: begin
                if (i_size == '0) begin
                    o_job.status = bsf_pkg::STATUS_DONE;
                end else if (tri_range) begin
                    o_job.status = bsf_pkg::STATUS_RANGE;
                end else begin
                    o_job.kind   = bsf_pkg::JOB_DRAW;
                    o_job.row_up = !i_corner[1];
                    // widest row at the corner, narrowing away from it
                    if (i_corner[0]) begin
                        o_job.hi      = bsf_pkg::COL_W'(i_x_start) + bsf_pkg::COL_W'(tri_w);
                        o_job.hi_step = bsf_pkg::STEP_DEC;
                    end else begin
                        o_job.lo      = bsf_pkg::COL_W'(i_x_start) - bsf_pkg::COL_W'(tri_w);
                        o_job.lo_step = bsf_pkg::STEP_INC;
                    end
                end
            end
            bsf_pkg::MODE_LINE: begin
                if (ln_range) begin
                    o_job.status = bsf_pkg::STATUS_RANGE;
                end else if (ln_slope) begin
                    o_job.status = bsf_pkg::STATUS_SLOPE;
                end else if (ay == '0) begin
                    // horizontal run or single point
                    o_job.kind  = bsf_pkg::JOB_DRAW;
                    o_job.count = bsf_pkg::CNT_W'(1);
                    o_job.lo    = (i_x_end > i_x_start) ? i_x_start : i_x_end;
                    o_job.hi    = (i_x_end > i_x_start) ? i_x_end : i_x_start;
                end else begin
                    // vertical or diagonal: one pixel per row
                    o_job.kind   = bsf_pkg::JOB_DRAW;
                    o_job.row_up = (i_y_end < i_y_start);
                    o_job.count  = bsf_pkg::CNT_W'(ay) + bsf_pkg::CNT_W'(1);
                    if (ax != '0) begin
                        o_job.lo_step = (i_x_end > i_x_start) ?
                                        bsf_pkg::STEP_INC : bsf_pkg::STEP_DEC;
                        o_job.hi_step = o_job.lo_step;
                    end
                end
            end
            bsf_pkg::MODE_READ: begin
                if (bsf_pkg::CFG_W'(i_y_start) >= eff_h) begin
                    o_job.status = bsf_pkg::STATUS_RANGE;
                end else if (eff_w != '0) begin
                    o_job.kind = bsf_pkg::JOB_READ;
                    o_job.lo   = '0;
                    o_job.hi   = bsf_pkg::COL_W'(eff_w - bsf_pkg::CFG_W'(1));
                end
            end
            default: ;
        endcase
    end

endmodule

>>> hdl/bsf_queue.sv
// short job queue between front end and back end
`timescale 1ns / 1ps

module bsf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bsf_pkg::t_job        i_job,
    output logic                 o_full,
    input  logic                 i_pop,
    output bsf_pkg::t_queue_rd   o_rd
);

    bsf_pkg::t_job               r_entry [bsf_pkg::QUEUE_DEPTH];
    logic [bsf_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [bsf_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [bsf_pkg::QCNT_W-1:0]  r_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full   = (r_count == bsf_pkg::QCNT_W'(bsf_pkg::QUEUE_DEPTH));
    assign o_rd.empty = (r_count == '0);
    assign o_rd.job   = r_entry[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && !o_rd.empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == bsf_pkg::QPTR_W'(bsf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + bsf_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == bsf_pkg::QPTR_W'(bsf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + bsf_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + bsf_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - bsf_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/bsf_back.sv
// back end: row fill sequencer over the canvas ram and result register
`timescale 1ns / 1ps

module bsf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsf_pkg::t_queue_rd             i_q,
    output logic                           o_q_pop,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [bsf_pkg::STATUS_W-1:0]   o_status,
    output logic [bsf_pkg::MAX_COLUMNS-1:0] o_row_bits
);

    localparam int MC = bsf_pkg::MAX_COLUMNS;

    bsf_pkg::t_back_state r_state, n_state;

    logic [bsf_pkg::ROW_W-1:0]    r_row, n_row;
    logic                         r_row_up, n_row_up;
    logic [bsf_pkg::CNT_W-1:0]    r_count, n_count;
    logic [bsf_pkg::COL_W-1:0]    r_lo, n_lo;
    logic [bsf_pkg::COL_W-1:0]    r_hi, n_hi;
    bsf_pkg::t_step               r_lo_step, n_lo_step;
    bsf_pkg::t_step               r_hi_step, n_hi_step;
    logic [bsf_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [MC-1:0]                r_res_row, n_res_row;

    logic                         r_wr_valid, n_wr_valid;
    logic [bsf_pkg::ROW_W-1:0]    r_wr_addr, n_wr_addr;
    logic [MC-1:0]                r_wr_mask, n_wr_mask;
    logic [bsf_pkg::MAX_ROWS-1:0] r_row_valid, n_row_valid;

    logic                         r_out_valid, n_out_valid;
    logic [bsf_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [MC-1:0]                r_out_row, n_out_row;

    logic [bsf_pkg::ROW_W-1:0]    rd_addr;
    logic [MC-1:0]                rd_data;
    logic [MC-1:0]                old_row;
    logic [MC-1:0]                span_mask;
    logic                         out_free;

    // contiguous column span lo..hi
    function automatic logic [MC-1:0] col_span(input logic [bsf_pkg::COL_W-1:0] lo,
                                               input logic [bsf_pkg::COL_W-1:0] hi);
        logic [MC-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (bsf_pkg::COL_W'(MC - 1) - hi));
    endfunction

    // one column step of a span edge
    function automatic logic [bsf_pkg::COL_W-1:0] col_step(
        input logic [bsf_pkg::COL_W-1:0] col, input bsf_pkg::t_step step);
        logic [bsf_pkg::COL_W-1:0] res;
        unique case (step)
            bsf_pkg::STEP_INC: res = col + bsf_pkg::COL_W'(1);
            bsf_pkg::STEP_DEC: res = col - bsf_pkg::COL_W'(1);
            default:           res = col;
        endcase
        return res;
    endfunction

    bsf_ram #(
        .WIDTH (MC),
        .DEPTH (bsf_pkg::MAX_ROWS)
    ) u_canvas (
        .i_clk     (i_clk),
        .i_wr_en   (r_wr_valid),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (old_row | r_wr_mask),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign span_mask = col_span(r_lo, r_hi);
    assign out_free  = !r_out_valid || i_pop;

    // rows never written read as blank; address matches last cycle's read
    assign old_row = r_row_valid[r_wr_addr] ? rd_data : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsf_pkg::BK_IDLE: begin
                if (!i_q.empty) begin
                    unique case (i_q.job.kind)
                        bsf_pkg::JOB_DRAW: n_state = bsf_pkg::BK_DRAW;
                        bsf_pkg::JOB_READ: n_state = bsf_pkg::BK_READ;
                        default:           n_state = bsf_pkg::BK_FINISH;
                    endcase
                end
            end
            bsf_pkg::BK_DRAW: begin
                if (r_count == bsf_pkg::CNT_W'(1)) begin
                    n_state = bsf_pkg::BK_FINISH;
                end
            end
            bsf_pkg::BK_READ:      n_state = bsf_pkg::BK_READ_DATA;
            bsf_pkg::BK_READ_DATA: n_state = bsf_pkg::BK_FINISH;
            bsf_pkg::BK_FINISH: begin
                if (out_free) begin
                    n_state = bsf_pkg::BK_IDLE;
                end
            end
            default: n_state = bsf_pkg::BK_IDLE;
        endcase
    end

    // datapath and ram control
    always_comb begin
        o_q_pop      = 1'b0;
        rd_addr      = r_row;
        n_row        = r_row;
        n_row_up     = r_row_up;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_lo_step    = r_lo_step;
        n_hi_step    = r_hi_step;
        n_res_status = r_res_status;
        n_res_row    = r_res_row;
        n_wr_valid   = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_wr_mask    = r_wr_mask;
        n_row_valid  = r_row_valid;
        n_out_valid  = r_out_valid && !i_pop;
        n_out_status = r_out_status;
        n_out_row    = r_out_row;

        // pending read-modify-write lands this cycle
        if (r_wr_valid) begin
            n_row_valid[r_wr_addr] = 1'b1;
        end

        unique case (r_state)
            bsf_pkg::BK_IDLE: begin
                if (!i_q.empty) begin
                    o_q_pop      = 1'b1;
                    n_row        = i_q.job.row;
                    n_row_up     = i_q.job.row_up;
                    n_count      = i_q.job.count;
                    n_lo         = i_q.job.lo;
                    n_hi         = i_q.job.hi;
                    n_lo_step    = i_q.job.lo_step;
                    n_hi_step    = i_q.job.hi_step;
                    n_res_status = i_q.job.status;
                    n_res_row    = '0;
                end
            end
            bsf_pkg::BK_DRAW: begin
                // read this row now, merge the span into it next cycle
                n_wr_valid = 1'b1;
                n_wr_addr  = r_row;
                n_wr_mask  = span_mask;
                n_count    = r_count - bsf_pkg::CNT_W'(1);
                n_row      = r_row_up ? (r_row - bsf_pkg::ROW_W'(1)) :
                                        (r_row + bsf_pkg::ROW_W'(1));
                n_lo       = col_step(r_lo, r_lo_step);
                n_hi       = col_step(r_hi, r_hi_step);
            end
            bsf_pkg::BK_READ: begin
                n_wr_addr = r_row;
            end
            bsf_pkg::BK_READ_DATA: begin
                n_res_row = old_row & span_mask;
            end
            bsf_pkg::BK_FINISH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_row    = r_res_row;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bsf_pkg::BK_IDLE;
            r_wr_valid  <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_valid  <= n_wr_valid;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_row_up     <= n_row_up;
        r_count      <= n_count;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_lo_step    <= n_lo_step;
        r_hi_step    <= n_hi_step;
        r_res_status <= n_res_status;
        r_res_row    <= n_res_row;
        r_wr_addr    <= n_wr_addr;
        r_wr_mask    <= n_wr_mask;
        r_out_status <= n_out_status;
        r_out_row    <= n_out_row;
    end

    assign o_empty    = !r_out_valid;
    assign o_status   = r_out_status;
    assign o_row_bits = r_out_row;

endmodule
